[design/mfbe_pkg.sv]
// Shared types, constants and helper functions of the mixed Fischer-Burmeister element unit.
`default_nettype none

package mfbe_pkg;

   // Number format and problem size.
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAX_DIM   = 256;
   localparam int IDX_W     = 8;
   localparam int CFG_W     = 9;

   // Square root and divider depths.
   localparam int ROOT_W   = 32;
   localparam int RAD_W    = 64;
   localparam int SQ_STEPS = ROOT_W;
   localparam int QUO_W    = FRAC_BITS + 1;
   localparam int NUM_W    = DATA_W + FRAC_BITS;
   localparam int DV_STEPS = QUO_W;

   // Wide intermediate widths of the back end.
   localparam int COEF_W = QUO_W + 1;
   localparam int PROD_W = COEF_W + DATA_W;
   localparam int WIDE_W = 36;

   localparam logic signed [COEF_W-1:0] Q_ONE     = COEF_W'(1 << FRAC_BITS);
   localparam logic signed [COEF_W-1:0] Q_NEG_ONE = -Q_ONE;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_EQ_ROWS     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SIZE = 8'd1;

   // Item data that rides alongside the square root and divider.
   typedef struct packed {
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] f;
      logic signed [DATA_W-1:0] jac;
      logic                     diag;
      logic                     eq;
      logic                     ierr;
   } side_type;

   // Magnitude of a signed word as an unsigned word of the same width.
   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   // Clip a wide signed value to 32 bits; the top bit of the result is the clip flag.
   function automatic logic [DATA_W:0] sat_wide(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] max_v;
      logic signed [WIDE_W-1:0] min_v;
      max_v = WIDE_W'(36'sh0_7FFF_FFFF);
      min_v = WIDE_W'(36'shF_8000_0000);
      if (v > max_v) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < min_v) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[DATA_W-1:0]};
   endfunction

endpackage

`default_nettype wire

[design/mfbe_if.sv]
// Handshake channel interfaces of the mixed Fischer-Burmeister element unit.
`default_nettype none

interface mfbe_req_if;
   import mfbe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         row_index;
   logic [IDX_W-1:0]         col_index;
   logic signed [DATA_W-1:0] z_value;
   logic signed [DATA_W-1:0] f_value;
   logic signed [DATA_W-1:0] jac_in;
   modport source (output valid, row_index, col_index, z_value, f_value, jac_in,
                   input ready);
   modport sink   (input valid, row_index, col_index, z_value, f_value, jac_in,
                   output ready);
endinterface

interface mfbe_rsp_if;
   import mfbe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] phi_value;
   logic signed [DATA_W-1:0] jac_out;
   logic                     saturated;
   logic                     index_error;
   modport source (output valid, phi_value, jac_out, saturated, index_error,
                   input ready);
   modport sink   (input valid, phi_value, jac_out, saturated, index_error,
                   output ready);
endinterface

interface mfbe_csr_if;
   import mfbe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/mfbe_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module mfbe_sqrt import mfbe_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire side_type          in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [ROOT_W-1:0]      out_root,
   output side_type               out_side
);

   logic [SQ_STEPS-1:0] v_ff;
   logic [SQ_STEPS:0]   ld;
   logic [RAD_W-1:0]    x_ff   [SQ_STEPS];
   logic [RAD_W-1:0]    res_ff [SQ_STEPS];
   side_type            side_ff[SQ_STEPS];

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      ld[SQ_STEPS] = out_ready;
      for (int s = SQ_STEPS - 1; s >= 0; s--) begin
         ld[s] = !v_ff[s] || ld[s+1];
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[SQ_STEPS-1];
   assign out_root  = res_ff[SQ_STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[SQ_STEPS-1];

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stage
      localparam int K = SQ_STEPS - 1 - s;
      logic             prev_v;
      logic [RAD_W-1:0] prev_x;
      logic [RAD_W-1:0] prev_res;
      side_type         prev_side;
      logic [RAD_W-1:0] trial;
      logic [RAD_W-1:0] x_in;
      logic [RAD_W-1:0] res_in;

      if (s == 0) begin : g_first
         assign prev_v    = in_valid;
         assign prev_x    = in_rad;
         assign prev_res  = '0;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_v    = v_ff[s-1];
         assign prev_x    = x_ff[s-1];
         assign prev_res  = res_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      // Try the next root bit against the remaining radicand.
      always_comb begin
         trial = prev_res + (RAD_W'(1) << (2 * K));
         if (prev_x >= trial) begin
            x_in   = prev_x - trial;
            res_in = (prev_res >> 1) + (RAD_W'(1) << (2 * K));
         end else begin
            x_in   = prev_x;
            res_in = prev_res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (ld[s]) begin
            v_ff[s] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[s]) begin
            x_ff[s]    <= x_in;
            res_ff[s]  <= res_in;
            side_ff[s] <= prev_side;
         end
      end
   end

endmodule

`default_nettype wire

[design/mfbe_div.sv]
// Pipelined two-lane restoring divider that forms z/r and F/r, one quotient bit per stage.
`default_nettype none

module mfbe_div import mfbe_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire side_type          in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [QUO_W-1:0]       out_qz,
   output logic [QUO_W-1:0]       out_qf,
   output logic [ROOT_W-1:0]      out_root,
   output side_type               out_side
);

   logic [DV_STEPS-1:0] v_ff;
   logic [DV_STEPS:0]   ld;
   logic [NUM_W-1:0]    remz_ff[DV_STEPS];
   logic [NUM_W-1:0]    remf_ff[DV_STEPS];
   logic [QUO_W-1:0]    qz_ff  [DV_STEPS];
   logic [QUO_W-1:0]    qf_ff  [DV_STEPS];
   logic [ROOT_W-1:0]   root_ff[DV_STEPS];
   side_type            side_ff[DV_STEPS];

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      ld[DV_STEPS] = out_ready;
      for (int s = DV_STEPS - 1; s >= 0; s--) begin
         ld[s] = !v_ff[s] || ld[s+1];
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[DV_STEPS-1];
   assign out_qz    = qz_ff[DV_STEPS-1];
   assign out_qf    = qf_ff[DV_STEPS-1];
   assign out_root  = root_ff[DV_STEPS-1];
   assign out_side  = side_ff[DV_STEPS-1];

   for (genvar s = 0; s < DV_STEPS; s++) begin : g_stage
      localparam int I = DV_STEPS - 1 - s;
      logic              prev_v;
      logic [NUM_W-1:0]  prev_remz;
      logic [NUM_W-1:0]  prev_remf;
      logic [QUO_W-1:0]  prev_qz;
      logic [QUO_W-1:0]  prev_qf;
      logic [ROOT_W-1:0] prev_root;
      side_type          prev_side;
      logic [NUM_W:0]    dsr;
      logic [NUM_W-1:0]  remz_in;
      logic [NUM_W-1:0]  remf_in;
      logic [QUO_W-1:0]  qz_in;
      logic [QUO_W-1:0]  qf_in;

      if (s == 0) begin : g_first
         assign prev_v    = in_valid;
         assign prev_remz = {mag32(in_side.z), FRAC_BITS'(0)};
         assign prev_remf = {mag32(in_side.f), FRAC_BITS'(0)};
         assign prev_qz   = '0;
         assign prev_qf   = '0;
         assign prev_root = in_root;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_v    = v_ff[s-1];
         assign prev_remz = remz_ff[s-1];
         assign prev_remf = remf_ff[s-1];
         assign prev_qz   = qz_ff[s-1];
         assign prev_qf   = qf_ff[s-1];
         assign prev_root = root_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      // Subtract the shifted divisor where it fits and set that quotient bit.
      always_comb begin
         dsr     = (NUM_W + 1)'(prev_root) << I;
         remz_in = prev_remz;
         remf_in = prev_remf;
         qz_in   = prev_qz;
         qf_in   = prev_qf;
         if ({1'b0, prev_remz} >= dsr) begin
            remz_in  = prev_remz - dsr[NUM_W-1:0];
            qz_in[I] = 1'b1;
         end
         if ({1'b0, prev_remf} >= dsr) begin
            remf_in  = prev_remf - dsr[NUM_W-1:0];
            qf_in[I] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (ld[s]) begin
            v_ff[s] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[s]) begin
            remz_ff[s] <= remz_in;
            remf_ff[s] <= remf_in;
            qz_ff[s]   <= qz_in;
            qf_ff[s]   <= qf_in;
            root_ff[s] <= prev_root;
            side_ff[s] <= prev_side;
         end
      end
   end

endmodule

`default_nettype wire

[design/mixed_fischer_burmeister_element.sv]
// Top level of the mixed Fischer-Burmeister element unit.
// Each beat on the request channel carries one matrix element and yields one response beat
// with phi_i and element ij of the Jacobian of phi, in order. The unit takes a new beat every
// cycle unless stalled. It has three front stages (decode, squares, sum), 32 square root
// stages that settle one root bit each, 17 divider stages that settle one quotient bit each
// for z/r and F/r side by side, a multiply stage and a final add and clip stage that is also
// the output register. Stalls on the response side fill empty stages before back-pressure
// reaches the request side. Configuration writes are taken at any time with ready held high.
`default_nettype none

module mixed_fischer_burmeister_element import mfbe_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   mfbe_req_if.sink    req_bus,
   mfbe_rsp_if.source  rsp_bus,
   mfbe_csr_if.sink    csr_bus
);

   // Configuration registers.
   logic [CFG_W-1:0] eq_rows_ff;
   logic [CFG_W-1:0] active_size_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_rows_ff     <= '0;
         active_size_ff <= CFG_W'(MAX_DIM);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_EQ_ROWS:     eq_rows_ff     <= csr_bus.data[CFG_W-1:0];
            CSR_ACTIVE_SIZE: active_size_ff <= csr_bus.data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake chain of the front and back stages.
   logic a_v_ff, b_v_ff, c_v_ff, m_v_ff, f_v_ff;
   logic ld_a, ld_b, ld_c, ld_m, ld_f;
   logic sq_in_ready, sq_out_valid, dv_in_ready, dv_out_valid;

   assign ld_c = !c_v_ff || sq_in_ready;
   assign ld_b = !b_v_ff || ld_c;
   assign ld_a = !a_v_ff || ld_b;
   assign ld_f = !f_v_ff || rsp_bus.ready;
   assign ld_m = !m_v_ff || ld_f;
   assign req_bus.ready = ld_a;

   // Stage A: range and row class decode, magnitudes.
   logic [CFG_W-1:0]  dim;
   side_type          a_side_in;
   side_type          a_side_ff;
   logic [DATA_W-1:0] a_zm_ff, a_fm_ff;

   always_comb begin
      dim = (active_size_ff > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : active_size_ff;
      a_side_in.z    = req_bus.z_value;
      a_side_in.f    = req_bus.f_value;
      a_side_in.jac  = req_bus.jac_in;
      a_side_in.diag = req_bus.row_index == req_bus.col_index;
      a_side_in.eq   = {1'b0, req_bus.row_index} < eq_rows_ff;
      a_side_in.ierr = ({1'b0, req_bus.row_index} >= dim) || ({1'b0, req_bus.col_index} >= dim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (ld_a) begin
         a_v_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_a) begin
         a_side_ff <= a_side_in;
         a_zm_ff   <= mag32(req_bus.z_value);
         a_fm_ff   <= mag32(req_bus.f_value);
      end
   end

   // Stage B: squares of the magnitudes.
   side_type         b_side_ff;
   logic [RAD_W-1:0] b_sqz_ff, b_sqf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (ld_b) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_b) begin
         b_side_ff <= a_side_ff;
         b_sqz_ff  <= RAD_W'(a_zm_ff) * RAD_W'(a_zm_ff);
         b_sqf_ff  <= RAD_W'(a_fm_ff) * RAD_W'(a_fm_ff);
      end
   end

   // Stage C: radicand.
   side_type         c_side_ff;
   logic [RAD_W-1:0] c_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (ld_c) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_c) begin
         c_side_ff <= b_side_ff;
         c_rad_ff  <= b_sqz_ff + b_sqf_ff;
      end
   end

   // Square root and divider pipelines.
   logic [ROOT_W-1:0] sq_root, dv_root;
   side_type          sq_side, dv_side;
   logic [QUO_W-1:0]  dv_qz, dv_qf;

   mfbe_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_v_ff),
      .in_ready  (sq_in_ready),
      .in_rad    (c_rad_ff),
      .in_side   (c_side_ff),
      .out_valid (sq_out_valid),
      .out_ready (dv_in_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   mfbe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_out_valid),
      .in_ready  (dv_in_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_out_valid),
      .out_ready (ld_m),
      .out_qz    (dv_qz),
      .out_qf    (dv_qf),
      .out_root  (dv_root),
      .out_side  (dv_side)
   );

   // Stage M: coefficients a and b, and the product b * J.
   logic signed [COEF_W-1:0] a_coef, b_coef;
   logic signed [COEF_W-1:0] m_a_ff;
   logic signed [PROD_W-1:0] m_prod_ff;
   logic [ROOT_W-1:0]        m_root_ff;
   side_type                 m_side_ff;

   always_comb begin
      if (dv_root == '0) begin
         a_coef = Q_NEG_ONE;
         b_coef = Q_NEG_ONE;
      end else begin
         a_coef = (dv_side.z[DATA_W-1] ? -$signed({1'b0, dv_qz}) : $signed({1'b0, dv_qz}))
                  - Q_ONE;
         b_coef = (dv_side.f[DATA_W-1] ? -$signed({1'b0, dv_qf}) : $signed({1'b0, dv_qf}))
                  - Q_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (ld_m) begin
         m_v_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_m) begin
         m_a_ff    <= a_coef;
         m_prod_ff <= PROD_W'(b_coef) * PROD_W'(dv_side.jac);
         m_root_ff <= dv_root;
         m_side_ff <= dv_side;
      end
   end

   // Stage F: scale, diagonal term, phi, clipping and result selection.
   logic [PROD_W-1:0]        prod_mag;
   logic [PROD_W-1:0]        prod_shift;
   logic signed [WIDE_W-1:0] el_wide, phi_wide;
   logic [DATA_W:0]          el_sat, phi_sat;
   logic signed [DATA_W-1:0] f_phi_in, f_jac_in;
   logic                     f_sat_in;
   logic signed [DATA_W-1:0] f_phi_ff, f_jac_ff;
   logic                     f_sat_ff, f_ierr_ff;

   always_comb begin
      prod_mag   = m_prod_ff[PROD_W-1] ? PROD_W'(-m_prod_ff) : PROD_W'(m_prod_ff);
      prod_shift = prod_mag >> FRAC_BITS;
      el_wide    = m_prod_ff[PROD_W-1] ? -$signed(WIDE_W'(prod_shift))
                                       : $signed(WIDE_W'(prod_shift));
      if (m_side_ff.diag) begin
         el_wide = el_wide + WIDE_W'(m_a_ff);
      end
      phi_wide = $signed(WIDE_W'(m_root_ff)) - WIDE_W'(m_side_ff.z) - WIDE_W'(m_side_ff.f);
      el_sat   = sat_wide(el_wide);
      phi_sat  = sat_wide(phi_wide);
      if (m_side_ff.ierr) begin
         f_phi_in = '0;
         f_jac_in = '0;
         f_sat_in = 1'b0;
      end else if (m_side_ff.eq) begin
         f_phi_in = m_side_ff.f;
         f_jac_in = m_side_ff.jac;
         f_sat_in = 1'b0;
      end else begin
         f_phi_in = phi_sat[DATA_W-1:0];
         f_jac_in = el_sat[DATA_W-1:0];
         f_sat_in = phi_sat[DATA_W] || el_sat[DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (ld_f) begin
         f_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_f) begin
         f_phi_ff  <= f_phi_in;
         f_jac_ff  <= f_jac_in;
         f_sat_ff  <= f_sat_in;
         f_ierr_ff <= m_side_ff.ierr;
      end
   end

   assign rsp_bus.valid       = f_v_ff;
   assign rsp_bus.phi_value   = f_phi_ff;
   assign rsp_bus.jac_out     = f_jac_ff;
   assign rsp_bus.saturated   = f_sat_ff;
   assign rsp_bus.index_error = f_ierr_ff;

endmodule

`default_nettype wire

[sim/mixed_fischer_burmeister_element_test.sv]
// Testbench for the mixed Fischer-Burmeister element unit: directed table, random beats, scoreboard.
`default_nettype none

module mixed_fischer_burmeister_element_test;
   import mfbe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_BEATS = 620;

   typedef struct packed {
      logic signed [DATA_W-1:0] phi;
      logic signed [DATA_W-1:0] jac;
      logic                     sat;
      logic                     ierr;
   } fb_result_type;

   typedef struct packed {
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] f;
      logic signed [DATA_W-1:0] jac;
      logic                     typed;
      fb_result_type            want;
   } element_row_type;

   logic clock;
   logic reset;

   mfbe_req_if req_bus ();
   mfbe_rsp_if rsp_bus ();
   mfbe_csr_if csr_bus ();

   mixed_fischer_burmeister_element dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // Local copy of the configuration registers.
   logic [CFG_W-1:0] eq_rows_reg;
   logic [CFG_W-1:0] active_size_reg;

   fb_result_type pending_results[$];
   int            mismatch_count;
   int            checked_count;
   int            cycle_count;
   int            send_max_gap;
   int            recv_max_stall;
   logic          beat_typed;
   fb_result_type beat_want;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of the integer square root.
   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 64'd0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Clip to the 32-bit signed range and raise the clip flag.
   function automatic logic signed [DATA_W-1:0] clip32(input longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   // Expected phi and Jacobian element for one matrix element.
   function automatic fb_result_type fb_element(input element_row_type e);
      fb_result_type res;
      int unsigned   dim;
      longint        z;
      longint        f;
      longint        jac;
      longint        a;
      longint        b;
      longint        p;
      longint        el;
      logic [63:0]   zm;
      logic [63:0]   fm;
      logic [63:0]   r;
      logic [63:0]   q;
      logic          flag;
      res  = '0;
      flag = 1'b0;
      dim  = active_size_reg > MAX_DIM ? MAX_DIM : active_size_reg;
      if (e.row >= dim || e.col >= dim) begin
         res.ierr = 1'b1;
         return res;
      end
      if (e.row < eq_rows_reg) begin
         res.phi = e.f;
         res.jac = e.jac;
         return res;
      end
      z   = e.z;
      f   = e.f;
      jac = e.jac;
      zm  = z < 0 ? -z : z;
      fm  = f < 0 ? -f : f;
      r   = root_floor(zm * zm + fm * fm);
      if (r > 0) begin
         q = (zm << FRAC_BITS) / r;
         a = (z < 0 ? -longint'(q) : longint'(q)) - 65536;
         q = (fm << FRAC_BITS) / r;
         b = (f < 0 ? -longint'(q) : longint'(q)) - 65536;
      end else begin
         a = -65536;
         b = -65536;
      end
      p  = b * jac;
      q  = (p < 0 ? -p : p) >> FRAC_BITS;
      el = p < 0 ? -longint'(q) : longint'(q);
      if (e.row == e.col) el = el + a;
      res.phi = clip32(longint'(r) - z - f, flag);
      res.jac = clip32(el, flag);
      res.sat = flag;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
   endtask

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Record the expected result of every accepted request beat.
   always @(posedge clock) begin
      element_row_type e;
      if (!reset && req_bus.valid && req_bus.ready) begin
         e = '{req_bus.row_index, req_bus.col_index, req_bus.z_value, req_bus.f_value,
               req_bus.jac_in, 1'b0, '0};
         pending_results.push_back(beat_typed ? beat_want : fb_element(e));
      end
   end

   // Response side: random stalls per beat, compare each accepted beat.
   int stall_left;
   always @(posedge clock) begin
      fb_result_type want;
      int            next_stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         next_stall = stall_left;
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_count++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", rsp_bus.phi_value, 32'h0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.phi_value !== want.phi)
                  report_mismatch("phi_value", rsp_bus.phi_value, want.phi);
               if (rsp_bus.jac_out !== want.jac)
                  report_mismatch("jac_out", rsp_bus.jac_out, want.jac);
               if (rsp_bus.saturated !== want.sat)
                  report_mismatch("saturated", 32'(rsp_bus.saturated), 32'(want.sat));
               if (rsp_bus.index_error !== want.ierr)
                  report_mismatch("index_error", 32'(rsp_bus.index_error), 32'(want.ierr));
            end
            next_stall = $urandom_range(recv_max_stall, 0);
         end
         if (next_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= next_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left    <= 0;
         end
      end
   end

   // Write one configuration register; upper data bits are ignored by the unit.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= {23'($urandom_range(8388607, 0)), value[CFG_W-1:0]};
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_EQ_ROWS) eq_rows_reg = value[CFG_W-1:0];
      if (idx == CSR_ACTIVE_SIZE) active_size_reg = value[CFG_W-1:0];
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Present one element; valid stays high straight into the next beat when no gap is drawn.
   task automatic send_element(input element_row_type e);
      int gap;
      gap = $urandom_range(send_max_gap, 0);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.row_index <= e.row;
      req_bus.col_index <= e.col;
      req_bus.z_value   <= e.z;
      req_bus.f_value   <= e.f;
      req_bus.jac_in    <= e.jac;
      beat_typed        <= e.typed;
      beat_want         <= e.want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every expected beat has arrived.
   task automatic drain;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Random operand with weight on zero, extremes and small values.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7, 0))
         0: return 32'sh0;
         1: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2, 3: return $signed($urandom_range(1 << 20, 0)) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   // Random index, mostly inside the active size.
   function automatic logic [IDX_W-1:0] pick_index();
      int unsigned dim;
      dim = active_size_reg > MAX_DIM ? MAX_DIM : active_size_reg;
      if (dim == 0 || $urandom_range(9, 0) == 0) return IDX_W'($urandom);
      return IDX_W'($urandom_range(dim - 1, 0));
   endfunction

   element_row_type directed[$];
   element_row_type e;
   int              sent;
   int              phase;
   int unsigned     eq_setting;
   int unsigned     size_setting;

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.row_index = '0;
      req_bus.col_index = '0;
      req_bus.z_value   = '0;
      req_bus.f_value   = '0;
      req_bus.jac_in    = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = CSR_EQ_ROWS;
      csr_bus.data   = '0;
      rsp_bus.ready  = 1'b0;
      beat_typed     = 1'b0;
      beat_want      = '0;
      eq_rows_reg    = 9'd0;
      active_size_reg = 9'd256;
      mismatch_count = 0;
      checked_count  = 0;
      cycle_count    = 0;
      send_max_gap   = 0;
      recv_max_stall = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Beats under the reset configuration, no idling.
      directed.push_back('{8'd0, 8'd0, 32'sh0, 32'sh0, 32'sh0, 1'b1,
                           '{32'sh0, 32'shFFFF_0000, 1'b0, 1'b0}});
      directed.push_back('{8'd255, 8'd255, 32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b0, '0});
      foreach (directed[i]) send_element(directed[i]);
      drain();

      // Directed table with two equality rows in a dimension of ten.
      write_register(CSR_EQ_ROWS, 2);
      write_register(CSR_ACTIVE_SIZE, 10);
      send_max_gap   = 3;
      recv_max_stall = 3;
      directed = '{
         '{8'd12, 8'd0, 32'sh1, 32'sh2, 32'sh3, 1'b1, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
         '{8'd0, 8'd200, 32'sh1, 32'sh2, 32'sh3, 1'b1, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
         '{8'd10, 8'd10, 32'sh1, 32'sh2, 32'sh3, 1'b1, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
         '{8'd1, 8'd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1,
           '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0}},
         '{8'd0, 8'd0, 32'sh1234_5678, 32'shFFFF_FFFF, 32'sh8000_0000, 1'b1,
           '{32'shFFFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0}},
         '{8'd2, 8'd2, 32'sh0, 32'sh0, 32'sh7FFF_FFFF, 1'b0, '0},
         '{8'd3, 8'd4, 32'sh0, 32'sh0, 32'sh8000_0000, 1'b0, '0},
         '{8'd3, 8'd3, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '0},
         '{8'd4, 8'd4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
         '{8'd5, 8'd6, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
         '{8'd6, 8'd6, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '0},
         '{8'd7, 8'd7, 32'sh0001_0000, 32'sh0, 32'sh0003_0000, 1'b0, '0},
         '{8'd8, 8'd9, 32'sh0, 32'shFFFF_0000, 32'sh0002_0000, 1'b0, '0},
         '{8'd9, 8'd9, 32'shFFFF_FFFF, 32'sh1, 32'shFFFF_FFFF, 1'b0, '0},
         '{8'd9, 8'd2, 32'sh0003_0000, 32'sh0004_0000, 32'sh8000_0000, 1'b0, '0}
      };
      foreach (directed[i]) send_element(directed[i]);
      drain();

      // Random phases over several settings, the extremes among them.
      sent = 0;
      for (phase = 0; sent < RANDOM_BEATS; phase++) begin
         case (phase % 8)
            0: begin eq_setting = 0;   size_setting = 256; end
            1: begin eq_setting = 256; size_setting = 256; end
            2: begin eq_setting = 0;   size_setting = 511; end
            3: begin eq_setting = 0;   size_setting = 0;   end
            4: begin eq_setting = 20;  size_setting = 5;   end
            5: begin eq_setting = 0;   size_setting = 1;   end
            6: begin eq_setting = 511; size_setting = 300; end
            default: begin
               eq_setting   = $urandom_range(511, 0);
               size_setting = $urandom_range(511, 0);
            end
         endcase
         write_register(CSR_EQ_ROWS, eq_setting);
         write_register(CSR_ACTIVE_SIZE, size_setting);
         send_max_gap   = (phase % 3 == 0) ? 0 : 12;
         recv_max_stall = (phase % 4 == 1) ? 0 : 12;
         repeat (40) begin
            e.row   = pick_index();
            e.col   = $urandom_range(3, 0) == 0 ? e.row : pick_index();
            e.z     = pick_value();
            e.f     = pick_value();
            e.jac   = pick_value();
            e.typed = 1'b0;
            e.want  = '0;
            send_element(e);
            sent++;
         end
         drain();
      end

      repeat (60) @(posedge clock);
      $display("Covered %0d response beats over %0d register settings,", checked_count,
               phase + 2);
      $display("with equality rows, index errors, clipping and zero radius exercised.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/mfbe_pkg.sv
design/mfbe_if.sv
design/mfbe_sqrt.sv
design/mfbe_div.sv
design/mixed_fischer_burmeister_element.sv
sim/mixed_fischer_burmeister_element_test.sv
